// ===== hdl/jsm_pkg.sv =====
// Package for the jump search membership block: command codes, widths,
// controller states and the controller/datapath interface structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package jsm_pkg;

	localparam int DEPTH_DEFAULT = 1024;
	localparam int VALUE_W       = 32;
	localparam int CMD_W         = 2;

	localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
	localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQRT,
		ST_JLOAD,
		ST_JUMP,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_APPEND,
		OP_CLEAR,
		OP_QSTART,
		OP_SQRT,
		OP_JLOAD,
		OP_JUMP_ADV,
		OP_SCAN_START,
		OP_SCAN_ADV
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   res_wr;
		logic   res_val;
		logic   out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic count_zero;
		logic sqrt_last;
		logic jump_in_range;
		logic jump_lt;
		logic jump_eq;
		logic scan_in_range;
		logic scan_eq;
	} dp_status_t;

endpackage

`default_nettype wire

// ===== hdl/jsm_dp.sv =====
// Datapath of the jump search block: entry memory, entry count, bit-serial
// square root, jump and scan pointers, result register.
// Depends on jsm_pkg; driven by jsm_ctrl through jsm_pkg::dp_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module jsm_dp #(
	parameter int DEPTH = jsm_pkg::DEPTH_DEFAULT
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire jsm_pkg::dp_cmd_t                  dcmd,
	input  wire logic signed [jsm_pkg::VALUE_W-1:0] value,
	output jsm_pkg::dp_status_t                    status,
	output logic                                   found
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int RW = (CW + 1) / 2;
	localparam int IW = CW + 1;
	localparam int SW = 2 * RW;

	logic signed [jsm_pkg::VALUE_W-1:0] mem [DEPTH];
	logic signed [jsm_pkg::VALUE_W-1:0] rd_q;
	logic signed [jsm_pkg::VALUE_W-1:0] key_q;
	logic [CW-1:0] count_q;
	logic [RW-1:0] root_q;
	logic [RW-1:0] bit_q;
	logic [IW-1:0] it_q;
	logic [CW-1:0] prev_q;
	logic [CW-1:0] end_q;
	logic          res_q;
	logic          found_q;

	logic [RW-1:0] trial;
	logic [SW-1:0] trial_sq;
	logic [IW-1:0] it_next;
	logic [IW-1:0] count_ext;
	logic [IW-1:0] rd_ptr;
	logic          has_room;

	assign trial     = root_q | bit_q;
	assign trial_sq  = SW'(trial) * SW'(trial);
	assign count_ext = IW'(count_q);
	assign it_next   = it_q + IW'(root_q);
	assign has_room  = count_q < CW'(DEPTH);

	// read pointer follows the pointer the next cycle will compare against
	always_comb begin
		unique case (dcmd.op)
			jsm_pkg::OP_JLOAD:      rd_ptr = IW'(root_q);
			jsm_pkg::OP_JUMP_ADV:   rd_ptr = it_next;
			jsm_pkg::OP_SCAN_ADV:   rd_ptr = IW'(prev_q) + IW'(1);
			default:                rd_ptr = IW'(prev_q);
		endcase
	end

	always_ff @(posedge clk) begin
		if (dcmd.op == jsm_pkg::OP_APPEND && has_room) begin
			mem[count_q[AW-1:0]] <= value;
		end
		rd_q <= mem[rd_ptr[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			if (dcmd.op == jsm_pkg::OP_APPEND && has_room) begin
				count_q <= count_q + CW'(1);
			end else if (dcmd.op == jsm_pkg::OP_CLEAR) begin
				count_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (dcmd.op)
			jsm_pkg::OP_QSTART: begin
				key_q  <= value;
				root_q <= '0;
				bit_q  <= {1'b1, {(RW-1){1'b0}}};
			end
			jsm_pkg::OP_SQRT: begin
				if (trial_sq <= SW'(count_q)) begin
					root_q <= trial;
				end
				bit_q <= bit_q >> 1;
			end
			jsm_pkg::OP_JLOAD: begin
				it_q   <= IW'(root_q);
				prev_q <= '0;
			end
			jsm_pkg::OP_JUMP_ADV: begin
				prev_q <= it_q[CW-1:0];
				it_q   <= it_next;
			end
			jsm_pkg::OP_SCAN_START: begin
				end_q <= status.jump_in_range ? it_q[CW-1:0] : count_q;
			end
			jsm_pkg::OP_SCAN_ADV: begin
				prev_q <= prev_q + CW'(1);
			end
			default: begin
			end
		endcase
		if (dcmd.res_wr) begin
			res_q <= dcmd.res_val;
		end
		if (dcmd.out_load) begin
			found_q <= res_q;
		end
	end

	always_comb begin
		status.count_zero    = (count_q == '0);
		status.sqrt_last     = bit_q[0];
		status.jump_in_range = (it_q < count_ext);
		status.jump_lt       = (rd_q < key_q);
		status.jump_eq       = (rd_q == key_q);
		status.scan_in_range = (prev_q < end_q);
		status.scan_eq       = (rd_q == key_q);
	end

	assign found = found_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_root_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		dcmd.op == jsm_pkg::OP_JLOAD |-> root_q != '0)
		else $error("jump distance is zero on a non-empty table");

	a_jump_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		dcmd.op == jsm_pkg::OP_JUMP_ADV |-> it_q < count_ext)
		else $error("jump advanced past the table end");

	a_scan_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		dcmd.op == jsm_pkg::OP_SCAN_ADV |-> prev_q < count_q && end_q <= count_q)
		else $error("scan read beyond written entries");
`endif

endmodule

`default_nettype wire

// ===== hdl/jsm_ctrl.sv =====
// Controller of the jump search block: request handshake, search sequencing
// and the output register handshake. Depends on jsm_pkg; drives jsm_dp.
`timescale 1ns / 1ps
`default_nettype none

module jsm_ctrl (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic [jsm_pkg::CMD_W-1:0] cmd,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	input  wire jsm_pkg::dp_status_t       status,
	output jsm_pkg::dp_cmd_t               dcmd
);

	jsm_pkg::state_t state_q;
	jsm_pkg::state_t state_d;
	logic            out_valid_q;
	logic            out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			jsm_pkg::ST_IDLE: begin
				if (in_valid && cmd == jsm_pkg::CMD_QUERY) begin
					state_d = status.count_zero ? jsm_pkg::ST_DONE : jsm_pkg::ST_SQRT;
				end
			end
			jsm_pkg::ST_SQRT: begin
				if (status.sqrt_last) begin
					state_d = jsm_pkg::ST_JLOAD;
				end
			end
			jsm_pkg::ST_JLOAD: state_d = jsm_pkg::ST_JUMP;
			jsm_pkg::ST_JUMP: begin
				priority if (status.jump_in_range && status.jump_lt) begin
					state_d = jsm_pkg::ST_JUMP;
				end else if (status.jump_in_range && status.jump_eq) begin
					state_d = jsm_pkg::ST_DONE;
				end else begin
					state_d = jsm_pkg::ST_SCAN;
				end
			end
			jsm_pkg::ST_SCAN: begin
				if (!status.scan_in_range || status.scan_eq) begin
					state_d = jsm_pkg::ST_DONE;
				end
			end
			jsm_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = jsm_pkg::ST_IDLE;
				end
			end
			default: state_d = jsm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall      = 1'b1;
		dcmd.op       = jsm_pkg::OP_NONE;
		dcmd.res_wr   = 1'b0;
		dcmd.res_val  = 1'b0;
		dcmd.out_load = 1'b0;
		unique case (state_q)
			jsm_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					unique case (cmd)
						jsm_pkg::CMD_APPEND: dcmd.op = jsm_pkg::OP_APPEND;
						jsm_pkg::CMD_CLEAR:  dcmd.op = jsm_pkg::OP_CLEAR;
						jsm_pkg::CMD_QUERY: begin
							// empty table answers not found at once
							if (status.count_zero) begin
								dcmd.res_wr = 1'b1;
							end else begin
								dcmd.op = jsm_pkg::OP_QSTART;
							end
						end
						default: dcmd.op = jsm_pkg::OP_NONE;
					endcase
				end
			end
			jsm_pkg::ST_SQRT:  dcmd.op = jsm_pkg::OP_SQRT;
			jsm_pkg::ST_JLOAD: dcmd.op = jsm_pkg::OP_JLOAD;
			jsm_pkg::ST_JUMP: begin
				priority if (status.jump_in_range && status.jump_lt) begin
					dcmd.op = jsm_pkg::OP_JUMP_ADV;
				end else if (status.jump_in_range && status.jump_eq) begin
					dcmd.res_wr  = 1'b1;
					dcmd.res_val = 1'b1;
				end else begin
					dcmd.op = jsm_pkg::OP_SCAN_START;
				end
			end
			jsm_pkg::ST_SCAN: begin
				priority if (!status.scan_in_range) begin
					dcmd.res_wr = 1'b1;
				end else if (status.scan_eq) begin
					dcmd.res_wr  = 1'b1;
					dcmd.res_val = 1'b1;
				end else begin
					dcmd.op = jsm_pkg::OP_SCAN_ADV;
				end
			end
			jsm_pkg::ST_DONE: dcmd.out_load = out_free;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= jsm_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (dcmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

`ifndef ASSERT_OFF
	a_load_only_free: assert property (@(posedge clk) disable iff (!arst_n)
		dcmd.out_load |-> out_free)
		else $error("result loaded over a pending one");

	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != jsm_pkg::ST_IDLE |-> in_stall)
		else $error("request taken during a search");

	a_done_follows_result: assert property (@(posedge clk) disable iff (!arst_n)
		dcmd.res_wr |=> state_q == jsm_pkg::ST_DONE)
		else $error("result written without reaching done");
`endif

endmodule

`default_nettype wire

// ===== hdl/jump_search_membership.sv =====
// Append, clear and unused commands are taken in idle; a query on an empty table answers
// not found. Other queries use the bit-serial square root of the entry count (root width
// 6 at 1024) as jump distance, jump over checkpoints below the key, then scan the entries
// passed over, except on a checkpoint match. One request is handled at a time and the walk
// reads the single entry memory port once per cycle. A result waits in the output register.
// Reset clears the entry count and control; entry contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module jump_search_membership #(
	parameter int DEPTH = jsm_pkg::DEPTH_DEFAULT
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic [jsm_pkg::CMD_W-1:0]          cmd,
	input  wire logic signed [jsm_pkg::VALUE_W-1:0] value,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic                                    found
);

	jsm_pkg::dp_cmd_t    dcmd;
	jsm_pkg::dp_status_t status;

	jsm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.dcmd      (dcmd)
	);

	jsm_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.dcmd   (dcmd),
		.value  (value),
		.status (status),
		.found  (found)
	);

endmodule

`default_nettype wire
